FILE: rtl/eil4_pkg.sv
// Package for the Ethernet/IPv4/L4 header extractor.
// Holds the frame offsets, protocol codes and the result summary type.
// It has no dependencies.
package eil4_pkg;

   localparam int unsigned ETH_LEN      = 14;
   localparam int unsigned HDR_MIN      = 34;
   localparam int unsigned TYPE_HI_POS  = 12;
   localparam int unsigned TYPE_LO_POS  = 13;
   localparam int unsigned IHL_POS      = 14;
   localparam int unsigned PROTO_POS    = 23;
   localparam int unsigned SADDR_FIRST  = 26;
   localparam int unsigned SADDR_LAST   = 29;
   localparam int unsigned DADDR_FIRST  = 30;
   localparam int unsigned DADDR_LAST   = 33;
   localparam int unsigned TCP_HDR_LEN  = 20;
   localparam int unsigned UDP_HDR_LEN  = 8;
   localparam int unsigned SPORT_HI_REL = 0;
   localparam int unsigned SPORT_LO_REL = 1;
   localparam int unsigned DPORT_HI_REL = 2;
   localparam int unsigned DPORT_LO_REL = 3;
   localparam int unsigned FLAGS_REL    = 13;
   localparam int unsigned LEN_W        = 12;

   localparam logic [15:0] IPV4_TYPE = 16'h0800;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   typedef enum logic [1:0] {
      PORTS_NONE = 2'd0,
      PORTS_TCP  = 2'd1,
      PORTS_UDP  = 2'd2
   } ports_kind_type;

   typedef struct packed {
      logic [31:0]      frame_number;
      logic [LEN_W-1:0] frame_length;
      logic [15:0]      ether_type;
      logic             is_ipv4;
      logic [7:0]       ip_protocol;
      logic [31:0]      source_address;
      logic [31:0]      dest_address;
      ports_kind_type   ports_kind;
      logic [15:0]      source_port;
      logic [15:0]      dest_port;
      logic [4:0]       tcp_flag_bits;
   } summary_type;

endpackage

FILE: rtl/eil4_capture.sv
// Per-frame field capture and frame summary for the header extractor.
// Holds the byte position, captured header fields and the frame counter.
// Depends on eil4_pkg.
module eil4_capture #(
   parameter int unsigned MAX_FRAME = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           frame_byte,
   input  logic                 last_byte,
   output logic                 emit,
   output eil4_pkg::summary_type summary
);

   localparam int unsigned PW = $clog2(MAX_FRAME + 1);

   logic [PW-1:0] pos_ff, pos_in, pos_nx, rel, off_x;
   logic [15:0]   type_ff, type_in, type_nx;
   logic [3:0]    hw_ff, hw_in, hw_nx;
   logic [7:0]    proto_ff, proto_in, proto_nx;
   logic [31:0]   saddr_ff, saddr_in, saddr_nx;
   logic [31:0]   daddr_ff, daddr_in, daddr_nx;
   logic [15:0]   sport_ff, sport_in, sport_nx;
   logic [15:0]   dport_ff, dport_in, dport_nx;
   logic [4:0]    flag_ff, flag_in, flag_nx;
   logic [31:0]   count_ff, count_in;
   logic [6:0]    off;
   logic          in_range;
   logic          ipv4;
   eil4_pkg::ports_kind_type kind;

   always_comb begin
      pos_nx   = pos_ff;
      type_nx  = type_ff;
      hw_nx    = hw_ff;
      proto_nx = proto_ff;
      saddr_nx = saddr_ff;
      daddr_nx = daddr_ff;
      sport_nx = sport_ff;
      dport_nx = dport_ff;
      flag_nx  = flag_ff;
      rel      = '0;
      in_range = pos_ff < PW'(MAX_FRAME);

      if (in_range) begin
         pos_nx = pos_ff + PW'(1);
         if (pos_ff == PW'(eil4_pkg::TYPE_HI_POS)) begin
            type_nx = {frame_byte, type_ff[7:0]};
         end else if (pos_ff == PW'(eil4_pkg::TYPE_LO_POS)) begin
            type_nx = {type_ff[15:8], frame_byte};
         end else if (pos_ff == PW'(eil4_pkg::IHL_POS)) begin
            hw_nx = frame_byte[3:0];
         end else if (pos_ff == PW'(eil4_pkg::PROTO_POS)) begin
            proto_nx = frame_byte;
         end else if (pos_ff >= PW'(eil4_pkg::SADDR_FIRST) &&
                      pos_ff <= PW'(eil4_pkg::SADDR_LAST)) begin
            saddr_nx = {saddr_ff[23:0], frame_byte};
         end else if (pos_ff >= PW'(eil4_pkg::DADDR_FIRST) &&
                      pos_ff <= PW'(eil4_pkg::DADDR_LAST)) begin
            daddr_nx = {daddr_ff[23:0], frame_byte};
         end
      end

      // The L4 offset already sees an IHL nibble taken from this same byte.
      off   = 7'(eil4_pkg::ETH_LEN) + {1'b0, hw_nx, 2'b00};
      off_x = PW'(off);

      if (in_range && pos_ff >= PW'(eil4_pkg::ETH_LEN) && pos_ff >= off_x) begin
         rel = pos_ff - off_x;
         if (rel == PW'(eil4_pkg::SPORT_HI_REL)) begin
            sport_nx = {frame_byte, sport_ff[7:0]};
         end else if (rel == PW'(eil4_pkg::SPORT_LO_REL)) begin
            sport_nx = {sport_ff[15:8], frame_byte};
         end else if (rel == PW'(eil4_pkg::DPORT_HI_REL)) begin
            dport_nx = {frame_byte, dport_ff[7:0]};
         end else if (rel == PW'(eil4_pkg::DPORT_LO_REL)) begin
            dport_nx = {dport_ff[15:8], frame_byte};
         end else if (rel == PW'(eil4_pkg::FLAGS_REL)) begin
            flag_nx = frame_byte[4:0];
         end
      end
   end

   always_comb begin
      ipv4 = type_nx == eil4_pkg::IPV4_TYPE;
      kind = eil4_pkg::PORTS_NONE;
      if (ipv4) begin
         if (proto_nx == eil4_pkg::PROTO_TCP &&
             pos_nx >= off_x + PW'(eil4_pkg::TCP_HDR_LEN)) begin
            kind = eil4_pkg::PORTS_TCP;
         end else if (proto_nx == eil4_pkg::PROTO_UDP &&
                      pos_nx >= off_x + PW'(eil4_pkg::UDP_HDR_LEN)) begin
            kind = eil4_pkg::PORTS_UDP;
         end
      end

      emit = last_byte && (pos_nx >= PW'(eil4_pkg::HDR_MIN));

      summary.frame_number   = count_ff + 32'd1;
      summary.frame_length   = eil4_pkg::LEN_W'(pos_nx);
      summary.ether_type     = type_nx;
      summary.is_ipv4        = ipv4;
      summary.ip_protocol    = ipv4 ? proto_nx : 8'd0;
      summary.source_address = ipv4 ? saddr_nx : 32'd0;
      summary.dest_address   = ipv4 ? daddr_nx : 32'd0;
      summary.ports_kind     = kind;
      summary.source_port    = (kind != eil4_pkg::PORTS_NONE) ? sport_nx : 16'd0;
      summary.dest_port      = (kind != eil4_pkg::PORTS_NONE) ? dport_nx : 16'd0;
      summary.tcp_flag_bits  = (kind == eil4_pkg::PORTS_TCP) ? flag_nx : 5'd0;
   end

   always_comb begin
      pos_in   = pos_ff;
      type_in  = type_ff;
      hw_in    = hw_ff;
      proto_in = proto_ff;
      saddr_in = saddr_ff;
      daddr_in = daddr_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      flag_in  = flag_ff;
      count_in = count_ff;
      if (step) begin
         if (last_byte) begin
            pos_in   = '0;
            type_in  = '0;
            hw_in    = '0;
            proto_in = '0;
            saddr_in = '0;
            daddr_in = '0;
            sport_in = '0;
            dport_in = '0;
            flag_in  = '0;
            count_in = count_ff + 32'd1;
         end else begin
            pos_in   = pos_nx;
            type_in  = type_nx;
            hw_in    = hw_nx;
            proto_in = proto_nx;
            saddr_in = saddr_nx;
            daddr_in = daddr_nx;
            sport_in = sport_nx;
            dport_in = dport_nx;
            flag_in  = flag_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         type_ff  <= '0;
         hw_ff    <= '0;
         proto_ff <= '0;
         saddr_ff <= '0;
         daddr_ff <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
         flag_ff  <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         hw_ff    <= hw_in;
         proto_ff <= proto_in;
         saddr_ff <= saddr_in;
         daddr_ff <= daddr_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         flag_ff  <= flag_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/eth_ipv4_l4_header_extractor_top.sv
// Top level of the Ethernet/IPv4/L4 header extractor.
// Holds the input byte register, the result register and the stream handshakes.
// Depends on eil4_pkg and eil4_capture.

// The block takes one frame byte per clock cycle unless the input is stalled
// (see below). Each byte passes through an input register and then updates
// the captured header fields, and the final byte of a frame loads the result
// register, from which the summary is offered. Input stalls only when a final
// byte finds the result register still holding a summary that has not been
// taken. Frames shorter than 34 bytes are counted but produce no summary, and
// bytes beyond MAX_FRAME are ignored until the final byte.
module eth_ipv4_l4_header_extractor_top #(
   parameter int unsigned MAX_FRAME = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] frame_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] frame_number, [43:32] frame_length, [59:44] ether_type,
   // [67:60] ip_protocol, [99:68] source_address, [131:100] dest_address,
   // [147:132] source_port, [163:148] dest_port, [168:164] tcp_flag_bits,
   // [175:169] zero
   output logic [175:0] rsp_tdata,
   // [0] is_ipv4, [2:1] ports_kind
   output logic [2:0]   rsp_tuser
);

   logic                  stage_valid_ff, stage_valid_in;
   logic [7:0]            stage_byte_ff;
   logic                  stage_last_ff;
   logic                  advance;
   logic                  emit;
   logic                  load;
   logic                  rsp_valid_ff, rsp_valid_in;
   eil4_pkg::summary_type summary;
   eil4_pkg::summary_type rsp_ff;

   assign advance = stage_valid_ff && !(stage_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign load = advance && emit;

   always_comb begin
      stage_valid_in = req_tready ? req_tvalid : stage_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   eil4_capture #(
      .MAX_FRAME(MAX_FRAME)
   ) u_capture (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .frame_byte(stage_byte_ff),
      .last_byte (stage_last_ff),
      .emit      (emit),
      .summary   (summary)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_byte_ff <= req_tdata;
         stage_last_ff <= req_tlast;
      end
      if (load) begin
         rsp_ff <= summary;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.tcp_flag_bits,
                        rsp_ff.dest_port,
                        rsp_ff.source_port,
                        rsp_ff.dest_address,
                        rsp_ff.source_address,
                        rsp_ff.ip_protocol,
                        rsp_ff.ether_type,
                        rsp_ff.frame_length,
                        rsp_ff.frame_number};
   assign rsp_tuser  = {rsp_ff.ports_kind, rsp_ff.is_ipv4};

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> stage_valid_ff && stage_last_ff && rsp_valid_ff)
      else $error("Input stalled without a pending final byte and full result.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff || rsp_tready)
      else $error("Result register overwritten before it was taken.");

   a_ports_need_ipv4: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ports_kind != eil4_pkg::PORTS_NONE |-> rsp_ff.is_ipv4)
      else $error("Ports reported for a frame that is not IPv4.");

   a_flags_only_tcp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ports_kind != eil4_pkg::PORTS_TCP
      |-> rsp_ff.tcp_flag_bits == 5'd0)
      else $error("TCP flags reported for a frame without a TCP header.");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the Ethernet/IPv4/L4 header extractor.
// A scoreboard class predicts one summary per frame of at least HDR_MIN bytes from the bytes that
// the block accepts; it depends on eil4_pkg and eth_ipv4_l4_header_extractor_top.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import eil4_pkg::*;

   localparam int unsigned MAX_FRAME = 2048;
   localparam int ITEMS = 900;

   class header_tracker;
      logic [11:0]   pos;
      logic [15:0]   etype;
      logic [3:0]    ihl;
      logic [7:0]    proto;
      logic [31:0]   saddr;
      logic [31:0]   daddr;
      logic [15:0]   sport;
      logic [15:0]   dport;
      logic [4:0]    flags;
      logic [31:0]   frames;
      summary_type   due_summaries[$];
      int            errors;

      function new();
         clear_frame();
         frames = '0;
         errors = 0;
      endfunction

      function void clear_frame();
         pos = '0;
         etype = '0;
         ihl = '0;
         proto = '0;
         saddr = '0;
         daddr = '0;
         sport = '0;
         dport = '0;
         flags = '0;
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         int unsigned off;
         int unsigned rel;
         summary_type s;
         if (pos < MAX_FRAME) begin
            if (pos == TYPE_HI_POS) etype[15:8] = b;
            else if (pos == TYPE_LO_POS) etype[7:0] = b;
            else if (pos == IHL_POS) ihl = b[3:0];
            else if (pos == PROTO_POS) proto = b;
            else if (pos >= SADDR_FIRST && pos <= SADDR_LAST) saddr = {saddr[23:0], b};
            else if (pos >= DADDR_FIRST && pos <= DADDR_LAST) daddr = {daddr[23:0], b};
            off = ETH_LEN + 4 * ihl;
            if (pos >= ETH_LEN && pos >= off) begin
               rel = pos - off;
               if (rel == SPORT_HI_REL) sport[15:8] = b;
               else if (rel == SPORT_LO_REL) sport[7:0] = b;
               else if (rel == DPORT_HI_REL) dport[15:8] = b;
               else if (rel == DPORT_LO_REL) dport[7:0] = b;
               else if (rel == FLAGS_REL) flags = b[4:0];
            end
            pos++;
         end
         if (!last) return;
         frames++;
         if (pos < HDR_MIN) begin
            clear_frame();
            return;
         end
         off = ETH_LEN + 4 * ihl;
         s = '0;
         s.frame_number = frames;
         s.frame_length = pos;
         s.ether_type = etype;
         s.is_ipv4 = (etype == IPV4_TYPE);
         s.ports_kind = PORTS_NONE;
         if (s.is_ipv4) begin
            s.ip_protocol = proto;
            s.source_address = saddr;
            s.dest_address = daddr;
            if (proto == PROTO_TCP && pos >= off + TCP_HDR_LEN) s.ports_kind = PORTS_TCP;
            else if (proto == PROTO_UDP && pos >= off + UDP_HDR_LEN) s.ports_kind = PORTS_UDP;
         end
         if (s.ports_kind != PORTS_NONE) begin
            s.source_port = sport;
            s.dest_port = dport;
         end
         if (s.ports_kind == PORTS_TCP) s.tcp_flag_bits = flags;
         due_summaries.push_back(s);
         clear_frame();
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want, logic [31:0] num);
         if (got !== want)
            report_mismatch($sformatf("frame %0d %s got %h want %h", num, name, got, want));
      endtask

      task check_summary(logic [175:0] data, logic [2:0] user);
         summary_type want;
         if (due_summaries.size() == 0) begin
            report_mismatch($sformatf("unexpected summary %h", data[31:0]));
            return;
         end
         want = due_summaries.pop_front();
         compare_field("frame_number", data[31:0], want.frame_number, want.frame_number);
         compare_field("frame_length", data[43:32], want.frame_length, want.frame_number);
         compare_field("ether_type", data[59:44], want.ether_type, want.frame_number);
         compare_field("is_ipv4", user[0], want.is_ipv4, want.frame_number);
         compare_field("ip_protocol", data[67:60], want.ip_protocol, want.frame_number);
         compare_field("source_address", data[99:68], want.source_address, want.frame_number);
         compare_field("dest_address", data[131:100], want.dest_address, want.frame_number);
         compare_field("ports_kind", user[2:1], want.ports_kind, want.frame_number);
         compare_field("source_port", data[147:132], want.source_port, want.frame_number);
         compare_field("dest_port", data[163:148], want.dest_port, want.frame_number);
         compare_field("tcp_flag_bits", data[168:164], want.tcp_flag_bits, want.frame_number);
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [175:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;

   header_tracker tracker = new();
   logic [7:0]    frame_bytes[$];
   bit            rx_hold_request = 1'b0;

   eth_ipv4_l4_header_extractor_top #(.MAX_FRAME(MAX_FRAME)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_byte(b, last);
   endtask

   task automatic send_frame(input bit no_gaps);
      int g;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
         g = no_gaps ? 0 : pick_gap();
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   task automatic make_frame(input int len, input logic [15:0] etype, input logic [7:0] ver_ihl,
                             input logic [7:0] proto, input int fill);
      frame_bytes.delete();
      for (int i = 0; i < len; i++)
         frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      if (len > TYPE_LO_POS) begin
         frame_bytes[TYPE_HI_POS] = etype[15:8];
         frame_bytes[TYPE_LO_POS] = etype[7:0];
      end
      if (len > IHL_POS) frame_bytes[IHL_POS] = ver_ihl;
      if (len > PROTO_POS) frame_bytes[PROTO_POS] = proto;
   endtask

   initial begin : result_side
      int stall_left;
      int hold_left;
      int r;
      bit calm;
      stall_left = 0;
      hold_left = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_summary(rsp_tdata, rsp_tuser);
         if ($urandom_range(149) == 0) calm = !calm;
         if (hold_left == 0 && rx_hold_request) begin
            hold_left = 400;
            rx_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm) begin
               r = $urandom_range(99);
               if (r < 12) stall_left = $urandom_range(1, 3);
               else if (r < 15) stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin : byte_side
      int random_bytes;
      int full_frames;
      int len;
      int off;
      int r;
      logic [15:0] etype;
      logic [7:0] ver_ihl;
      logic [7:0] proto;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short frames: a single byte and one byte under the header minimum.
      make_frame(1, 16'h0000, 8'h00, 8'h00, -1);
      send_frame(1'b0);
      make_frame(HDR_MIN - 1, IPV4_TYPE, 8'h45, PROTO_TCP, -1);
      send_frame(1'b0);
      // Minimum length, all zeros and all ones.
      make_frame(HDR_MIN, 16'h0000, 8'h00, 8'h00, 8'h00);
      send_frame(1'b1);
      make_frame(HDR_MIN, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      send_frame(1'b0);
      // TCP with the header exactly complete, then one byte short of it, then longer.
      make_frame(ETH_LEN + 20 + TCP_HDR_LEN, IPV4_TYPE, 8'h45, PROTO_TCP, -1);
      frame_bytes[ETH_LEN + 20 + FLAGS_REL] = 8'h1F;
      send_frame(1'b0);
      make_frame(ETH_LEN + 20 + TCP_HDR_LEN - 1, IPV4_TYPE, 8'h45, PROTO_TCP, -1);
      send_frame(1'b0);
      make_frame(ETH_LEN + 20 + TCP_HDR_LEN + 6, IPV4_TYPE, 8'h45, PROTO_TCP, -1);
      frame_bytes[ETH_LEN + 20 + FLAGS_REL] = 8'hE0;
      send_frame(1'b1);
      // UDP exactly complete and one byte short.
      make_frame(ETH_LEN + 20 + UDP_HDR_LEN, IPV4_TYPE, 8'h45, PROTO_UDP, -1);
      send_frame(1'b0);
      make_frame(ETH_LEN + 20 + UDP_HDR_LEN - 1, IPV4_TYPE, 8'h45, PROTO_UDP, -1);
      send_frame(1'b0);
      // IHL of zero and two: the L4 fields overlap the IP header.
      make_frame(40, IPV4_TYPE, 8'h40, PROTO_TCP, -1);
      send_frame(1'b0);
      make_frame(HDR_MIN, IPV4_TYPE, 8'h42, PROTO_UDP, -1);
      send_frame(1'b0);
      // Largest IHL with a full TCP header.
      make_frame(ETH_LEN + 60 + TCP_HDR_LEN, IPV4_TYPE, 8'h4F, PROTO_TCP, -1);
      send_frame(1'b0);
      // Other protocol, and a frame longer than the saturation length.
      make_frame(60, IPV4_TYPE, 8'h45, 8'd1, -1);
      send_frame(1'b0);
      make_frame(MAX_FRAME + 2, IPV4_TYPE, 8'h45, PROTO_TCP, -1);
      send_frame(1'b1);

      // Hold the result side off while minimum frames keep coming.
      rx_hold_request = 1'b1;
      for (int i = 0; i < 8; i++) begin
         make_frame(HDR_MIN, IPV4_TYPE, 8'h45, PROTO_UDP, -1);
         send_frame(1'b1);
      end

      random_bytes = 0;
      full_frames = 0;
      while (random_bytes < ITEMS || full_frames < 48) begin
         r = $urandom_range(99);
         etype = (r < 80) ? IPV4_TYPE : 16'($urandom);
         r = $urandom_range(99);
         ver_ihl = (r < 80) ? 8'h45 : 8'($urandom);
         r = $urandom_range(99);
         if (r < 40) proto = PROTO_TCP;
         else if (r < 80) proto = PROTO_UDP;
         else proto = 8'($urandom);
         off = ETH_LEN + 4 * ver_ihl[3:0];
         r = $urandom_range(99);
         if (r < 10) len = $urandom_range(1, HDR_MIN - 1);
         else if (r < 80) len = $urandom_range(HDR_MIN, (off + 24 > HDR_MIN) ? off + 24 : HDR_MIN);
         else len = $urandom_range(HDR_MIN, 160);
         make_frame(len, etype, ver_ihl, proto, -1);
         send_frame($urandom_range(3) == 0);
         random_bytes += len;
         if (len >= HDR_MIN) full_frames++;
      end

      req_tvalid <= 1'b0;
      while (tracker.due_summaries.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Verification failed");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/eil4_pkg.sv
rtl/eil4_capture.sv
rtl/eth_ipv4_l4_header_extractor_top.sv
tb/sv/testbench.sv
